// ===== rtl/core/assert_macros.svh =====
// Assertion macros included by the hash map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication that must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// ===== rtl/core/lphm_pkg.sv =====
package lphm_pkg;

    // Default geometry of the table.
    localparam int LPHM_SLOTS     = 256;
    localparam int LPHM_KEY_BYTES = 8;

    // Configuration port.
    localparam int       LPHM_AW            = 3;
    localparam logic [8:0] LPHM_TS_RESET    = 9'd256;

    // Register index of the table size.
    localparam logic LPHM_REG_TABLE_SIZE = 1'b0;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_UPDATED  = 3'd1,
        ST_HIT      = 3'd2,
        ST_MISS     = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

endpackage

// ===== rtl/core/linear_probe_hash_map.sv =====
// Channel  | Ports                                         | Handshake
// ---------+-----------------------------------------------+------------------------------
// request  | i_kind, i_key, i_value                        | taken when start & !busy
// result   | o_status, o_found_value, o_slot, o_occupied   | o_done, one cycle, no stall
// config   | psel, penable, pwrite, paddr, pwdata, prdata  | APB, pready always high
//
// A request runs through S_MOD once per bit of the key byte sum (SW bits, 11 for eight key
// bytes), then S_READ and S_CHECK for each slot probed (1 to table size) before its result.
// The remainder of the hash is found by one shared shift-subtract unit, one bit per cycle;
// each probe then costs one entry memory read and one compare.
// After reset a clearing pass writes every slot of the entry memory empty; busy stays high.
// busy falls in the cycle that shows the result, so the next request may follow at once.
`include "assert_macros.svh"

module linear_probe_hash_map
    import lphm_pkg::*;
#(
    parameter int SLOTS     = LPHM_SLOTS,
    parameter int KEY_BYTES = LPHM_KEY_BYTES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Request channel.
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_kind,
    input  logic [63:0]               i_key,
    input  logic signed [31:0]        i_value,
    // Result channel.
    output logic                      o_done,
    output logic [2:0]                o_status,
    output logic signed [31:0]        o_found_value,
    output logic [7:0]                o_slot,
    output logic [8:0]                o_occupied,
    // Configuration port.
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [LPHM_AW-1:0]        paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NW = $clog2(SLOTS + 1);
    localparam int TW = (NW > 9) ? NW : 9;
    localparam int SW = $clog2(KEY_BYTES * 255 + 1);
    localparam int SCW = $clog2(SW + 1);
    localparam int CW = (NW > SCW) ? NW : SCW;

    typedef struct packed {
        logic               valid;
        logic [63:0]        key;
        logic [31:0]        value;
    } t_entry;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK
    } t_state;

    // Entry memory.
    t_entry                 mem [SLOTS];
    t_entry                 r_rd;
    logic                   mem_we;
    logic [IW-1:0]          mem_addr;
    t_entry                 mem_wdata;

    // Sequencer and request registers.
    t_state                 r_state, n_state;
    logic                   r_kind, n_kind;
    logic [63:0]            r_key, n_key;
    logic [31:0]            r_value, n_value;
    logic [SW-1:0]          r_sum, n_sum;
    logic [NW-1:0]          r_rem, n_rem;
    logic [IW-1:0]          r_idx, n_idx;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [NW-1:0]          r_count, n_count;
    logic [8:0]             r_table_size;

    // Result registers.
    logic                   r_done, n_done;
    t_status                r_status, n_status;
    logic [31:0]            r_found, n_found;
    logic [IW-1:0]          r_slot, n_slot;

    // Datapath signals.
    logic [63:0]            norm_key;
    logic [SW-1:0]          key_sum;
    logic                   key_alive;
    logic [TW-1:0]          ts_wide;
    logic [NW-1:0]          n_eff;
    logic [NW:0]            shifted;
    logic [NW:0]            n_wide;
    logic [NW-1:0]          idx_inc;
    logic                   cfg_we;
    logic                   accept;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state != S_IDLE);

    // Key normalisation and byte sum: bytes after the first zero byte are dropped.
    always_comb begin
        norm_key  = '0;
        key_sum   = '0;
        key_alive = 1'b1;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (i_key[8*b +: 8] == 8'd0) begin
                key_alive = 1'b0;
            end
            if (key_alive) begin
                norm_key[8*b +: 8] = i_key[8*b +: 8];
                key_sum = key_sum + SW'(i_key[8*b +: 8]);
            end
        end
    end

    // Effective table size: zero acts as one, anything above SLOTS acts as SLOTS.
    always_comb begin
        ts_wide = TW'(r_table_size);
        if (ts_wide == '0) begin
            n_eff = NW'(1);
        end else if (ts_wide > TW'(SLOTS)) begin
            n_eff = NW'(SLOTS);
        end else begin
            n_eff = NW'(ts_wide);
        end
    end

    // Shared shift-subtract step and probe index advance.
    assign shifted = {r_rem, r_sum[SW-1]};
    assign n_wide  = {1'b0, n_eff};
    assign idx_inc = NW'(r_idx) + NW'(1);

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_key     = r_key;
        n_value   = r_value;
        n_sum     = r_sum;
        n_rem     = r_rem;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_count   = r_count;
        n_done    = 1'b0;
        n_status  = r_status;
        n_found   = r_found;
        n_slot    = r_slot;
        mem_we    = 1'b0;
        mem_addr  = r_idx;
        mem_wdata = '{valid: 1'b1, key: r_key, value: r_value};
        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '{valid: 1'b0, key: '0, value: '0};
                n_idx     = r_idx + IW'(1);
                if (r_idx == IW'(SLOTS - 1)) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_kind  = i_kind;
                    n_key   = norm_key;
                    n_value = i_value;
                    n_sum   = key_sum;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                // One remainder bit per cycle, most significant bit of the sum first.
                if (shifted >= n_wide) begin
                    n_rem = NW'(shifted - n_wide);
                end else begin
                    n_rem = NW'(shifted);
                end
                n_sum = r_sum << 1;
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(SW - 1)) begin
                    n_idx   = IW'(n_rem);
                    n_cnt   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!r_rd.valid) begin
                    // Empty slot ends the probe.
                    n_done  = 1'b1;
                    n_found = '0;
                    n_state = S_IDLE;
                    if (!r_kind) begin
                        mem_we   = 1'b1;
                        n_count  = r_count + NW'(1);
                        n_status = ST_INSERTED;
                        n_slot   = r_idx;
                    end else begin
                        n_status = ST_MISS;
                        n_slot   = '0;
                    end
                end else if (r_rd.key == r_key) begin
                    // Matching key: update or return the stored value.
                    n_done  = 1'b1;
                    n_slot  = r_idx;
                    n_state = S_IDLE;
                    if (!r_kind) begin
                        mem_we   = 1'b1;
                        n_status = ST_UPDATED;
                        n_found  = '0;
                    end else begin
                        n_status = ST_HIT;
                        n_found  = r_rd.value;
                    end
                end else if (r_cnt + CW'(1) == CW'(n_eff)) begin
                    // Every slot in use visited.
                    n_done   = 1'b1;
                    n_found  = '0;
                    n_slot   = '0;
                    n_status = r_kind ? ST_MISS : ST_FULL;
                    n_state  = S_IDLE;
                end else begin
                    n_cnt   = r_cnt + CW'(1);
                    n_idx   = (idx_inc >= n_eff) ? '0 : IW'(idx_inc);
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_status <= ST_INSERTED;
            r_found  <= '0;
            r_slot   <= '0;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_cnt    <= n_cnt;
            r_count  <= n_count;
            r_done   <= n_done;
            r_status <= n_status;
            r_found  <= n_found;
            r_slot   <= n_slot;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind  <= n_kind;
        r_key   <= n_key;
        r_value <= n_value;
        r_sum   <= n_sum;
        r_rem   <= n_rem;
    end

    // Entry memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rd <= mem[r_idx];
    end

    // Configuration register.
    assign cfg_we = psel && penable && pwrite && (paddr[2] == LPHM_REG_TABLE_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= LPHM_TS_RESET;
        end else if (cfg_we) begin
            r_table_size <= pwdata[8:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == LPHM_REG_TABLE_SIZE) ? {23'd0, r_table_size} : 32'd0;

    // Result ports.
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_value = r_found;
    assign o_slot        = 8'(r_slot);
    assign o_occupied    = 9'(r_count);

    // Checks on the sequencer and the occupancy count.
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, busy,
        "request accepted but block not busy")
    `ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, r_done, !busy,
        "result shown while still busy")
    `ASSERT_ALWAYS(a_count_range, i_clk, i_rst_n, r_count <= NW'(SLOTS),
        "occupancy count above table capacity")
    `ASSERT_IMPL(a_rem_range, i_clk, i_rst_n, r_state == S_MOD, r_rem < n_eff,
        "hash remainder not below table size")
    `ASSERT_IMPL(a_insert_count, i_clk, i_rst_n, r_done && (r_status == ST_INSERTED),
        r_count == $past(r_count) + NW'(1), "insert did not raise the occupancy count")

endmodule

// ===== test/tb_linear_probe_hash_map.sv =====
module tb_linear_probe_hash_map
    import lphm_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_SEARCH = 1'b1
    } t_op;

    typedef struct {
        t_status            status;
        logic signed [31:0] found;
        logic [7:0]         slot;
        logic [8:0]         occ;
    } t_result;

    typedef struct {
        bit          is_cfg;
        logic [8:0]  size;
        t_op         op;
        logic [63:0] key;
        logic [31:0] value;
        bit          typed;
        t_result     want;
    } t_row;

    localparam logic [LPHM_AW-1:0] TS_ADDR = LPHM_AW'(4 * LPHM_REG_TABLE_SIZE);
    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 600;
    localparam int PHASE_ITEMS = 200;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_kind;
    logic [63:0]        i_key;
    logic signed [31:0] i_value;
    logic               o_done;
    logic [2:0]         o_status;
    logic signed [31:0] o_found_value;
    logic [7:0]         o_slot;
    logic [8:0]         o_occupied;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [LPHM_AW-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow copy of the map, kept in step with accepted requests.
    bit          slot_used [256];
    logic [63:0] slot_key_m [256];
    logic [31:0] slot_val_m [256];
    int unsigned stored_count;
    logic [8:0]  tbl_size;

    t_result     awaited_results [$];
    logic [63:0] key_pool [$];
    t_row        directed [$];
    int          errors;
    int          quiet_cycles;
    t_result     got_want;

    linear_probe_hash_map DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_slot        (o_slot),
        .o_occupied    (o_occupied),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // Hashes the key, probes the shadow map and applies the request to it.
    function automatic t_result probe_map(t_op op, logic [63:0] raw, logic [31:0] val);
        t_result     r;
        logic [63:0] k;
        logic [10:0] sum;
        bit          ended;
        int          n;
        int          idx;
        int          i;
        k = '0;
        sum = '0;
        ended = 0;
        // The key ends at its first zero byte; later bytes are ignored.
        for (i = 0; i < 8; i++) begin
            if (raw[8*i +: 8] == 8'd0)
                ended = 1;
            if (!ended) begin
                k[8*i +: 8] = raw[8*i +: 8];
                sum += raw[8*i +: 8];
            end
        end
        n = (tbl_size == 0) ? 1 : ((tbl_size > 256) ? 256 : int'(tbl_size));
        idx = sum % n;
        r.status = (op == OP_SEARCH) ? ST_MISS : ST_FULL;
        r.found = '0;
        r.slot = '0;
        for (i = 0; i < n; i++) begin
            if (!slot_used[idx]) begin
                if (op == OP_INSERT) begin
                    slot_used[idx] = 1;
                    slot_key_m[idx] = k;
                    slot_val_m[idx] = val;
                    stored_count++;
                    r.status = ST_INSERTED;
                    r.slot = idx[7:0];
                end
                break;
            end
            if (slot_key_m[idx] == k) begin
                if (op == OP_INSERT) begin
                    slot_val_m[idx] = val;
                    r.status = ST_UPDATED;
                end else begin
                    r.found = slot_val_m[idx];
                    r.status = ST_HIT;
                end
                r.slot = idx[7:0];
                break;
            end
            idx = (idx + 1 == n) ? 0 : idx + 1;
        end
        r.occ = stored_count[8:0];
        return r;
    endfunction

    function automatic t_row req_row(t_op op, logic [63:0] key, logic [31:0] value, bit typed,
                                     t_status st, logic [31:0] found, logic [7:0] slot,
                                     logic [8:0] occ);
        t_row r;
        r.is_cfg = 0;
        r.size = '0;
        r.op = op;
        r.key = key;
        r.value = value;
        r.typed = typed;
        r.want.status = st;
        r.want.found = found;
        r.want.slot = slot;
        r.want.occ = occ;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [8:0] size);
        t_row r;
        r = req_row(OP_SEARCH, '0, '0, 0, ST_MISS, '0, '0, '0);
        r.is_cfg = 1;
        r.size = size;
        return r;
    endfunction

    // Key of 0 to 8 nonzero bytes, sometimes fully random or with rubbish after the terminator.
    function automatic logic [63:0] fresh_key();
        logic [63:0] k;
        int          len;
        int          i;
        k = '0;
        if ($urandom_range(0, 9) == 0)
            return {$urandom, $urandom};
        len = $urandom_range(0, 8);
        for (i = 0; i < len; i++)
            k[8*i +: 8] = 8'($urandom_range(1, 255));
        if (len < 7 && $urandom_range(0, 2) == 0) begin
            for (i = len + 1; i < 8; i++)
                k[8*i +: 8] = 8'($urandom);
        end
        return k;
    endfunction

    // Mostly reuses recent keys so that updates and hits are common.
    function automatic logic [63:0] pick_key();
        logic [63:0] k;
        int          i;
        bit          past_end;
        if (key_pool.size() != 0 && $urandom_range(0, 99) < 70) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            if ($urandom_range(0, 3) == 0) begin
                past_end = 0;
                for (i = 0; i < 8; i++) begin
                    if (past_end)
                        k[8*i +: 8] = 8'($urandom);
                    else if (k[8*i +: 8] == 8'd0)
                        past_end = 1;
                end
            end
        end else begin
            k = fresh_key();
            key_pool.push_back(k);
            if (key_pool.size() > 48)
                void'(key_pool.pop_front());
        end
        return k;
    endfunction

    // Issues one request, holds it until taken, then optionally goes quiet.
    task automatic send_request(input t_op op, input logic [63:0] key, input logic [31:0] value,
                                input bit typed, input t_result want, input int gap);
        t_result predicted;
        start <= 1'b1;
        i_kind <= op;
        i_key <= key;
        i_value <= value;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        predicted = probe_map(op, key, value);
        awaited_results.push_back(typed ? want : predicted);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Waits until every request has produced its result and the block is idle.
    task automatic drain();
        start <= 1'b0;
        while (awaited_results.size() != 0 || busy !== 1'b0)
            @(posedge i_clk);
    endtask

    // Writes the table size, then reads it back.
    task automatic write_table_size(input logic [8:0] size);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TS_ADDR;
        pwdata <= 32'(size);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        tbl_size = size;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[8:0] !== size) begin
            $error("table_size readback: expected %0d, actual %0d", size, prdata[8:0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result checker: every strobe must match the oldest outstanding request.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $error("result with no request outstanding: status %0d", o_status);
                errors++;
            end else begin
                got_want = awaited_results.pop_front();
                if (o_status !== got_want.status) begin
                    $error("status: expected %0d, actual %0d", got_want.status, o_status);
                    errors++;
                end
                if (o_found_value !== got_want.found) begin
                    $error("found_value: expected %0d, actual %0d", got_want.found,
                           o_found_value);
                    errors++;
                end
                if (o_slot !== got_want.slot) begin
                    $error("slot: expected %0d, actual %0d", got_want.slot, o_slot);
                    errors++;
                end
                if (o_occupied !== got_want.occ) begin
                    $error("occupied: expected %0d, actual %0d", got_want.occ, o_occupied);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles with neither a request taken nor a result shown.
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done === 1'b1 || (start && busy === 1'b0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int      i;
        int      p;
        int      gap;
        int      idle_pct;
        t_op     op;
        t_row    row;
        int      phase_size [8];
        t_result none;

        i_clk = 1'b0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_kind = 1'b0;
        i_key = '0;
        i_value = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        quiet_cycles = 0;
        stored_count = 0;
        tbl_size = LPHM_TS_RESET;
        for (i = 0; i < 256; i++)
            slot_used[i] = 0;
        none = '{ST_MISS, '0, '0, '0};

        // Directed table: empty key, byte extremes, collisions, size corner cases.
        directed.push_back(req_row(OP_SEARCH, 64'h0, 32'h0, 1, ST_MISS, 32'h0, 8'd0, 9'd0));
        directed.push_back(req_row(OP_INSERT, 64'h0, 32'd5, 1, ST_INSERTED, 32'h0, 8'd0, 9'd1));
        directed.push_back(req_row(OP_SEARCH, 64'h0, 32'h0, 1, ST_HIT, 32'd5, 8'd0, 9'd1));
        directed.push_back(req_row(OP_INSERT, 64'hFFFF_FFFF_FFFF_0041, 32'h1234_5678, 1,
                                   ST_INSERTED, 32'h0, 8'd65, 9'd2));
        directed.push_back(req_row(OP_SEARCH, 64'h41, 32'h0, 1, ST_HIT, 32'h1234_5678, 8'd65,
                                   9'd2));
        directed.push_back(req_row(OP_INSERT, '1, 32'h7FFF_FFFF, 1, ST_INSERTED, 32'h0, 8'd248,
                                   9'd3));
        directed.push_back(req_row(OP_INSERT, '1, 32'h8000_0000, 1, ST_UPDATED, 32'h0, 8'd248,
                                   9'd3));
        directed.push_back(req_row(OP_SEARCH, '1, 32'h0, 1, ST_HIT, 32'h8000_0000, 8'd248,
                                   9'd3));
        directed.push_back(req_row(OP_INSERT, 64'h4001, 32'hFFFF_FFFF, 1, ST_INSERTED, 32'h0,
                                   8'd66, 9'd4));
        directed.push_back(req_row(OP_SEARCH, 64'h4001, 32'h0, 1, ST_HIT, 32'hFFFF_FFFF, 8'd66,
                                   9'd4));
        directed.push_back(req_row(OP_SEARCH, 64'h4100, 32'h0, 1, ST_HIT, 32'd5, 8'd0, 9'd4));
        directed.push_back(cfg_row(9'd1));
        directed.push_back(req_row(OP_INSERT, 64'h42, 32'd7, 1, ST_FULL, 32'h0, 8'd0, 9'd4));
        directed.push_back(req_row(OP_SEARCH, 64'h42, 32'h0, 1, ST_MISS, 32'h0, 8'd0, 9'd4));
        directed.push_back(req_row(OP_INSERT, 64'h0, 32'd9, 0, ST_MISS, '0, '0, '0));
        directed.push_back(cfg_row(9'd0));
        directed.push_back(req_row(OP_SEARCH, 64'h0, 32'h0, 0, ST_MISS, '0, '0, '0));
        directed.push_back(cfg_row(9'h1FF));
        directed.push_back(req_row(OP_SEARCH, 64'h41, 32'h0, 0, ST_MISS, '0, '0, '0));
        directed.push_back(cfg_row(9'd2));
        directed.push_back(req_row(OP_SEARCH, 64'h41, 32'h0, 1, ST_MISS, 32'h0, 8'd0, 9'd4));
        directed.push_back(req_row(OP_INSERT, 64'h41, 32'd3, 1, ST_INSERTED, 32'h0, 8'd1, 9'd5));
        directed.push_back(req_row(OP_INSERT, 64'h03, 32'd1, 1, ST_FULL, 32'h0, 8'd0, 9'd5));
        directed.push_back(req_row(OP_SEARCH, '1, 32'hDEAD_BEEF, 0, ST_MISS, '0, '0, '0));

        // Reset, then let the clearing pass finish.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);

        foreach (directed[r]) begin
            row = directed[r];
            if (row.is_cfg) begin
                drain();
                write_table_size(row.size);
            end else begin
                send_request(row.op, row.key, row.value, row.typed, row.want,
                             $urandom_range(0, 1) ? $urandom_range(1, 20) : 0);
            end
        end

        // Random phases over a spread of table sizes and idling densities.
        phase_size = '{4, 256, 1, 16, 0, 511, 2, 3};
        phase_size[6] = $urandom_range(2, 64);
        for (p = 0; p < 8; p++) begin
            drain();
            write_table_size(9'(phase_size[p]));
            case (p % 4)
                1: begin
                    idle_pct = 66;
                end
                3: begin
                    idle_pct = 15;
                end
                default: begin
                    idle_pct = 0;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++) begin
                op = $urandom_range(0, 1) ? OP_SEARCH : OP_INSERT;
                gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 40) : 0;
                send_request(op, pick_key(), $urandom, 0, none, gap);
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && awaited_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/lphm_pkg.sv
rtl/core/linear_probe_hash_map.sv
test/tb_linear_probe_hash_map.sv
